FILE: design/crcfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the framed
// byte-stream receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

  // CRC-16/CCITT-FALSE: MSB first, no reflection, no final xor.
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START_FIRST  = 2'd0;
  localparam logic [1:0] CFG_START_SECOND = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN      = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] START_FIRST_RST  = 8'hAA;
  localparam logic [7:0] START_SECOND_RST = 8'h55;
  localparam logic [6:0] MAX_LEN_RST      = 7'd64;

  // Parser phases, one-hot.
  typedef enum logic [9:0] {
    PH_START0  = 10'b00_0000_0001,
    PH_START1  = 10'b00_0000_0010,
    PH_TYPE    = 10'b00_0000_0100,
    PH_SEQ_LO  = 10'b00_0000_1000,
    PH_SEQ_HI  = 10'b00_0001_0000,
    PH_LEN_LO  = 10'b00_0010_0000,
    PH_LEN_HI  = 10'b00_0100_0000,
    PH_PAYLOAD = 10'b00_1000_0000,
    PH_CRC_LO  = 10'b01_0000_0000,
    PH_CRC_HI  = 10'b10_0000_0000
  } phase_t;

  // Replay sequencer states, one-hot.
  typedef enum logic [1:0] {
    RP_IDLE = 2'b01,
    RP_LOAD = 2'b10
  } rp_state_t;

  // Configuration as seen by the parser.
  typedef struct packed {
    logic [7:0] start_first;
    logic [7:0] start_second;
    logic [6:0] max_len;
  } cfg_t;

  // Payload store write from the parser.
  typedef struct packed {
    logic       en;
    logic [6:0] idx;
    logic [7:0] data;
  } store_wr_t;

  // Frame accepted: header handed to the replay sequencer.
  typedef struct packed {
    logic        valid;
    logic [7:0]  frame_type;
    logic [15:0] sequence_res;
    logic [6:0]  length;
  } frame_req_t;

  // One result word.
  typedef struct packed {
    logic [7:0]  frame_type;
    logic [15:0] sequence_res;
    logic [6:0]  length;
    logic        has_data;
    logic [5:0]  byte_index;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

  // One byte step of the CRC, eight shift-and-xor steps.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: design/crcfr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module crcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read port whose data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/crcfr_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_parser
// Byte-level frame parser: start-byte hunt, header capture, running CRC,
// payload writes into the store and the CRC check at frame end.
// ----------------------------------------------------------------------------
module crcfr_parser
  import crcfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_fire,
  input  wire logic [7:0] in_byte,
  output store_wr_t       store_wr,
  output frame_req_t      req
);

  localparam logic [6:0] MAX_P = 7'(MAX_PAYLOAD);

  phase_t      phase, phase_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  held_type, held_type_next;
  logic [15:0] held_seq, held_seq_next;
  logic [7:0]  len_lo, len_lo_next;
  logic [6:0]  held_len, held_len_next;
  logic [6:0]  fill, fill_next;
  logic [7:0]  crc_lo, crc_lo_next;

  logic [15:0] crc_upd;
  logic [15:0] crc_restart;
  logic [6:0]  limit;
  logic [15:0] full_len;
  logic [6:0]  fill_inc;
  logic        crc_match;

  assign crc_upd     = crc_feed(crc, in_byte);
  assign crc_restart = crc_feed(CRC_INIT, in_byte);
  assign limit       = (cfg.max_len < MAX_P) ? cfg.max_len : MAX_P;
  assign full_len    = {in_byte, len_lo};
  assign fill_inc    = fill + 7'd1;
  assign crc_match   = ({in_byte, crc_lo} == crc);

  // Next-state logic for one accepted byte.
  always_comb begin
    phase_next     = phase;
    crc_next       = crc;
    held_type_next = held_type;
    held_seq_next  = held_seq;
    len_lo_next    = len_lo;
    held_len_next  = held_len;
    fill_next      = fill;
    crc_lo_next    = crc_lo;
    store_wr       = '0;
    req            = '0;
    if (in_fire) begin
      case (phase)
        PH_START1: begin
          if (in_byte == cfg.start_second) begin
            crc_next   = crc_upd;
            phase_next = PH_TYPE;
          end else if (in_byte == cfg.start_first) begin
            crc_next = crc_restart;
          end else begin
            phase_next = PH_START0;
          end
        end
        PH_TYPE: begin
          held_type_next = in_byte;
          crc_next       = crc_upd;
          phase_next     = PH_SEQ_LO;
        end
        PH_SEQ_LO: begin
          held_seq_next = {8'h00, in_byte};
          crc_next      = crc_upd;
          phase_next    = PH_SEQ_HI;
        end
        PH_SEQ_HI: begin
          held_seq_next = {in_byte, held_seq[7:0]};
          crc_next      = crc_upd;
          phase_next    = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_lo_next = in_byte;
          crc_next    = crc_upd;
          phase_next  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          crc_next = crc_upd;
          if (full_len > {9'd0, limit}) begin
            // Oversized frame: back to the hunt.
            phase_next    = PH_START0;
            held_len_next = '0;
            fill_next     = '0;
            crc_lo_next   = '0;
          end else if (full_len == 16'd0) begin
            held_len_next = '0;
            phase_next    = PH_CRC_LO;
          end else begin
            held_len_next = full_len[6:0];
            fill_next     = '0;
            phase_next    = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          store_wr.en   = 1'b1;
          store_wr.idx  = fill;
          store_wr.data = in_byte;
          crc_next      = crc_upd;
          fill_next     = fill_inc;
          if (fill_inc >= held_len) begin
            phase_next = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          crc_lo_next = in_byte;
          phase_next  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          req.valid        = crc_match;
          req.frame_type   = held_type;
          req.sequence_res = held_seq;
          req.length       = held_len;
          phase_next       = PH_START0;
          held_len_next    = '0;
          fill_next        = '0;
          crc_lo_next      = '0;
        end
        default: begin
          // Hunt for the first start byte; unused codes land here too.
          phase_next = PH_START0;
          if (in_byte == cfg.start_first) begin
            crc_next   = crc_restart;
            phase_next = PH_START1;
          end
        end
      endcase
    end
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START0;
      crc       <= CRC_INIT;
      held_type <= '0;
      held_seq  <= '0;
      len_lo    <= '0;
      held_len  <= '0;
      fill      <= '0;
      crc_lo    <= '0;
    end else begin
      phase     <= phase_next;
      crc       <= crc_next;
      held_type <= held_type_next;
      held_seq  <= held_seq_next;
      len_lo    <= len_lo_next;
      held_len  <= held_len_next;
      fill      <= fill_next;
      crc_lo    <= crc_lo_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/crcfr_replay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfr_replay
// Walks the payload store after a good frame and hands out one result word
// per payload byte (or one header-only word) through an output register.
// ----------------------------------------------------------------------------
module crcfr_replay
  import crcfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire frame_req_t                                  req,
  output logic                                             busy,
  output logic                                             rd_en,
  output logic [(MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1)-1:0] rd_addr,
  input  wire logic [7:0]                                  rd_data,
  output result_t                                          res,
  output logic                                             res_valid,
  input  wire logic                                        res_ready
);

  localparam int AW = MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1;

  rp_state_t   state;
  logic [6:0]  k;
  logic [7:0]  hdr_type;
  logic [15:0] hdr_seq;
  logic [6:0]  hdr_len;

  logic        has_data;
  logic [6:0]  count;
  logic [6:0]  k_inc;
  logic        is_last;
  logic        load;

  assign has_data = (hdr_len != 7'd0);
  assign count    = has_data ? hdr_len : 7'd1;
  assign k_inc    = k + 7'd1;
  assign is_last  = (k_inc == count);
  assign load     = (state == RP_LOAD) && (!res_valid || res_ready);
  assign busy     = (state != RP_IDLE);

  // Store reads: the first entry when a frame arrives, then one ahead of each load.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state == RP_IDLE) begin
      rd_en = req.valid && (req.length != 7'd0);
    end else if (load && !is_last) begin
      rd_en   = 1'b1;
      rd_addr = k_inc[AW-1:0];
    end
  end

  // Sequencer and counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RP_IDLE;
      k     <= '0;
    end else begin
      case (state)
        RP_IDLE: begin
          if (req.valid) begin
            state <= RP_LOAD;
            k     <= '0;
          end
        end
        RP_LOAD: begin
          if (load) begin
            if (is_last) begin
              state <= RP_IDLE;
            end else begin
              k <= k_inc;
            end
          end
        end
        default: begin
          state <= RP_IDLE;
        end
      endcase
    end
  end

  // Header of the frame being replayed.
  always_ff @(posedge clk) begin
    if (state == RP_IDLE && req.valid) begin
      hdr_type <= req.frame_type;
      hdr_seq  <= req.sequence_res;
      hdr_len  <= req.length;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.frame_type   <= hdr_type;
      res.sequence_res <= hdr_seq;
      res.length       <= hdr_len;
      res.has_data     <= has_data;
      res.byte_index   <= has_data ? k[5:0] : 6'd0;
      res.data_byte    <= has_data ? rd_data : 8'd0;
      res.last         <= is_last;
    end
  end

  // A new frame only arrives while the sequencer is idle.
  a_req_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid |-> state == RP_IDLE)
    else $error("frame request while replay busy");

  // A header-only word always closes its run.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.has_data) |-> res.last)
    else $error("empty frame word without last");

  // A payload word stays inside the frame length.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.has_data) |-> ({1'b0, res.byte_index} < res.length))
    else $error("byte index beyond frame length");

  // An accepted frame starts the replay on the next cycle.
  a_req_start: assert property (@(posedge clk) disable iff (rst)
    req.valid |=> state == RP_LOAD)
    else $error("replay did not start");

endmodule
`default_nettype wire

FILE: design/crc16_frame_receiver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_frame_receiver_top
// Framed byte-stream receiver with a CRC-16/CCITT-FALSE check and replay of
// accepted frames from a payload RAM.
// ----------------------------------------------------------------------------
// Received bytes are taken one per cycle on the s_ side while no frame is
// being replayed. When the second CRC byte of a good frame is taken, the input
// stalls (s_tready low) while the replay sequencer walks the payload RAM: one
// result word per cycle at best, paced by the single RAM read port and by
// m_tready. The input is held off until the last word of the frame (the
// only word for an empty frame) is loaded into the output register. A frame
// with a bad CRC or an oversized length costs nothing beyond its bytes. The
// payload RAM holds MAX_PAYLOAD bytes and needs no clearing after reset.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module crc16_frame_receiver_top
  import crcfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Received bytes. s_tdata: rx_byte[7:0].
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,
  // Results. m_tdata: frame_type[7:0], sequence_res[23:8], length[30:24],
  // byte_index[36:31], data_byte[44:37], zero fill [47:45].
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,
  // m_tuser: has_data[0].
  output logic             m_tuser,
  // m_tlast: last.
  output logic             m_tlast,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int AW = MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1;

  cfg_t            cfg;
  store_wr_t       store_wr;
  frame_req_t      req;
  result_t         res;
  logic            busy;
  logic            in_fire;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      rd_data;

  assign cfg_ready = 1'b1;
  assign s_tready  = !busy;
  assign in_fire   = s_tvalid && s_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_first  <= START_FIRST_RST;
      cfg.start_second <= START_SECOND_RST;
      cfg.max_len      <= MAX_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START_FIRST:  cfg.start_first  <= cfg_data;
        CFG_START_SECOND: cfg.start_second <= cfg_data;
        CFG_MAX_LEN:      cfg.max_len      <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Byte parser and CRC.
  crcfr_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_fire  (in_fire),
    .in_byte  (s_tdata),
    .store_wr (store_wr),
    .req      (req)
  );

  // Payload store.
  crcfr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (store_wr.en),
    .waddr (store_wr.idx[AW-1:0]),
    .wdata (store_wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Frame replay.
  crcfr_replay #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_replay (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res       (res),
    .res_valid (m_tvalid),
    .res_ready (m_tready)
  );

  // Output packing.
  assign m_tdata = {3'b000, res.data_byte, res.byte_index, res.length,
                    res.sequence_res, res.frame_type};
  assign m_tuser = res.has_data;
  assign m_tlast = res.last;

endmodule
`default_nettype wire

FILE: bench/crc16_frame_receiver_top_tb.sv
// ----------------------------------------------------------------------------
// crc16_frame_receiver_top_tb
// Self-checking bench for the framed byte-stream receiver. Bytes are sent one
// word at a time on the s_ side. A behavioral copy of the parser and of the
// CRC-16/CCITT-FALSE check runs on every accepted byte and queues the result
// words that a good frame must produce. Each word on the m_ side is compared
// field by field with the oldest queued word. A short table of directed
// frames comes first, then random frames under several register settings,
// with random gaps on the sender and random back-pressure on the receiver.
// ----------------------------------------------------------------------------
module crc16_frame_receiver_top_tb;
  import crcfr_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int PAYLOAD_DEPTH = 64;
  localparam int IDLE_PCT      = 9;
  localparam int DRAIN_CYCLES  = 8;
  localparam int TIMEOUT_CYCLES = 300000;

  // Index past the register list; the block must ignore writes to it.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // How a frame is introduced on the link.
  typedef enum logic [1:0] {
    LEAD_NONE,
    LEAD_REPEAT,
    LEAD_BROKEN
  } lead_t;

  // Where the expected words of a frame come from.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_EMPTY
  } chk_t;

  typedef struct {
    lead_t       lead;
    logic [7:0]  ftype;
    logic [15:0] seq;
    logic [15:0] len;
    bit          crc_ok;
    chk_t        chk;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_START_FIRST;
  logic [7:0]  cfg_data = '0;

  // Shadow registers and parser state of the behavioral copy.
  logic [7:0]  cfg_sf;
  logic [7:0]  cfg_ss;
  logic [6:0]  cfg_ml;
  phase_t      p_phase;
  logic [7:0]  p_type;
  logic [15:0] p_seq;
  logic [15:0] p_len;
  logic [6:0]  p_fill;
  logic [7:0]  p_store [PAYLOAD_DEPTH];
  logic [15:0] p_crc;
  logic [7:0]  p_crc_lo;

  result_t     frame_words_q [$];
  chk_t        chk_mode = CHK_MODEL;
  result_t     lit_word;
  int          idle_pct = IDLE_PCT;
  int          sent_bytes = 0;
  int          err_count = 0;
  int          word_count = 0;
  result_t     seen_word;
  result_t     due_word;
  frame_row_t  plan [9];

  crc16_frame_receiver_top #(
    .MAX_PAYLOAD(PAYLOAD_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("crc16_frame_receiver_top regression: fail");
    $finish;
  end

  // One CRC-16/CCITT-FALSE byte update, most significant bit first.
  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic logic [15:0] payload_limit();
    return (cfg_ml < PAYLOAD_DEPTH) ? 16'(cfg_ml) : 16'(PAYLOAD_DEPTH);
  endfunction

  function automatic void restart_hunt();
    p_phase  = PH_START0;
    p_len    = '0;
    p_fill   = '0;
    p_crc_lo = '0;
  endfunction

  // Advance the parser copy by one accepted byte and queue any frame words.
  function automatic void absorb_byte(input logic [7:0] b);
    int      count;
    result_t w;
    case (p_phase)
      PH_START1: begin
        if (b == cfg_ss) begin
          p_crc   = crc_next(p_crc, b);
          p_phase = PH_TYPE;
        end else if (b == cfg_sf) begin
          // A repeated first start byte restarts the hunt from itself.
          p_crc = crc_next(CRC_INIT, b);
        end else begin
          p_phase = PH_START0;
        end
      end
      PH_TYPE: begin
        p_type  = b;
        p_crc   = crc_next(p_crc, b);
        p_phase = PH_SEQ_LO;
      end
      PH_SEQ_LO: begin
        p_seq   = {8'h00, b};
        p_crc   = crc_next(p_crc, b);
        p_phase = PH_SEQ_HI;
      end
      PH_SEQ_HI: begin
        p_seq   = {b, p_seq[7:0]};
        p_crc   = crc_next(p_crc, b);
        p_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        p_len   = {8'h00, b};
        p_crc   = crc_next(p_crc, b);
        p_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        p_len = {b, p_len[7:0]};
        p_crc = crc_next(p_crc, b);
        if (p_len > payload_limit()) begin
          restart_hunt();
        end else if (p_len == 0) begin
          p_phase = PH_CRC_LO;
        end else begin
          p_fill  = '0;
          p_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (p_fill < PAYLOAD_DEPTH) p_store[p_fill[5:0]] = b;
        p_crc  = crc_next(p_crc, b);
        p_fill = p_fill + 7'd1;
        if (16'(p_fill) >= p_len) p_phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        p_crc_lo = b;
        p_phase  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        if ({b, p_crc_lo} == p_crc) begin
          count = (p_len == 0) ? 1 : int'(p_len);
          if (count > PAYLOAD_DEPTH) count = PAYLOAD_DEPTH;
          case (chk_mode)
            CHK_MODEL: begin
              for (int k = 0; k < count; k++) begin
                w.frame_type   = p_type;
                w.sequence_res = p_seq;
                w.length       = p_len[6:0];
                w.has_data     = (p_len != 0);
                w.byte_index   = (p_len != 0) ? 6'(k) : 6'd0;
                w.data_byte    = (p_len != 0) ? p_store[k] : 8'h00;
                w.last         = (k == count - 1);
                frame_words_q.push_back(w);
              end
            end
            CHK_EMPTY: frame_words_q.push_back(lit_word);
            default: ;
          endcase
        end
        restart_hunt();
      end
      default: begin
        p_phase = PH_START0;
        if (b == cfg_sf) begin
          p_crc   = crc_next(CRC_INIT, b);
          p_phase = PH_START1;
        end
      end
    endcase
  endfunction

  function automatic frame_row_t mk_row(input lead_t lead, input logic [7:0] ftype,
                                        input logic [15:0] seq, input logic [15:0] len,
                                        input bit crc_ok, input chk_t chk);
    frame_row_t r;
    r.lead   = lead;
    r.ftype  = ftype;
    r.seq    = seq;
    r.len    = len;
    r.crc_ok = crc_ok;
    r.chk    = chk;
    return r;
  endfunction

  // Report one wrong or unexpected result field and count it.
  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("MISMATCH word %0d %s: got 0x%0h, want 0x%0h", word_count, what, got, want);
    err_count++;
  endtask

  // Send one byte word, with an occasional one-cycle gap before it.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    absorb_byte(b);
    sent_bytes++;
  endtask

  // Hold the sender off until every queued word has come out, then drain.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (frame_words_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all registers in order; the spare index is written when asked.
  task automatic program_regs(input logic [7:0] sf, input logic [7:0] ss,
                              input logic [7:0] ml, input bit poke_spare);
    logic [1:0] idx_list [4];
    logic [7:0] val_list [4];
    int         n;
    idx_list = '{CFG_START_FIRST, CFG_START_SECOND, CFG_MAX_LEN, CFG_SPARE};
    val_list = '{sf, ss, ml, 8'($urandom_range(255))};
    n = poke_spare ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= val_list[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx_list[i])
        CFG_START_FIRST:  cfg_sf = val_list[i];
        CFG_START_SECOND: cfg_ss = val_list[i];
        CFG_MAX_LEN:      cfg_ml = val_list[i][6:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Build and send one frame; an oversized one stops after its header.
  task automatic send_frame(input lead_t lead, input logic [7:0] ftype,
                            input logic [15:0] seq, input logic [15:0] len, input bit crc_ok);
    logic [7:0]  frame_q [$];
    logic [15:0] crc;
    logic [7:0]  odd;
    case (lead)
      LEAD_REPEAT: send_byte(cfg_sf);
      LEAD_BROKEN: begin
        do odd = 8'($urandom_range(255)); while (odd == cfg_sf || odd == cfg_ss);
        send_byte(cfg_sf);
        send_byte(odd);
      end
      default: ;
    endcase
    frame_q = '{cfg_sf, cfg_ss, ftype, seq[7:0], seq[15:8], len[7:0], len[15:8]};
    if (len <= payload_limit()) begin
      repeat (len) frame_q.push_back(8'($urandom_range(255)));
      crc = CRC_INIT;
      foreach (frame_q[i]) crc = crc_next(crc, frame_q[i]);
      if (!crc_ok) crc ^= 16'(1 << $urandom_range(15));
      frame_q.push_back(crc[7:0]);
      frame_q.push_back(crc[15:8]);
    end
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  // Random frames with random content, mixed with noise and broken frames.
  task automatic random_phase(input int budget);
    int          stop_at;
    int          k;
    int          pick;
    int          shape;
    logic [15:0] lim;
    logic [15:0] len;
    lead_t       lead;
    stop_at = sent_bytes + budget;
    k = 0;
    while (sent_bytes < stop_at) begin
      lim  = payload_limit();
      pick = $urandom_range(99);
      if (k == 0) len = lim;
      else if (pick < 12) len = 16'd0;
      else if (pick < 17) len = lim;
      else if (pick < 21) len = lim + 16'd1;
      else if (pick < 24) len = 16'($urandom_range(16'hFFFF, int'(lim) + 1));
      else len = 16'($urandom_range((lim < 8) ? int'(lim) : 8, 1));
      shape = $urandom_range(99);
      lead  = LEAD_NONE;
      if (shape < 8) begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end else if (shape < 14) begin
        lead = LEAD_REPEAT;
      end else if (shape < 20) begin
        lead = LEAD_BROKEN;
      end else if (shape < 24) begin
        // A frame cut short; the next frame runs into its header.
        send_byte(cfg_sf);
        send_byte(cfg_ss);
        send_byte(8'($urandom_range(255)));
      end
      send_frame(lead, 8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)), len,
                 $urandom_range(99) >= 12);
      k++;
    end
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Compare every accepted result word with the oldest queued word.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_word.frame_type   = m_tdata[7:0];
      seen_word.sequence_res = m_tdata[23:8];
      seen_word.length       = m_tdata[30:24];
      seen_word.byte_index   = m_tdata[36:31];
      seen_word.data_byte    = m_tdata[44:37];
      seen_word.has_data     = m_tuser;
      seen_word.last         = m_tlast;
      if (frame_words_q.size() == 0) begin
        flag_mismatch("unexpected word", m_tdata[15:0], 16'h0000);
      end else begin
        due_word = frame_words_q.pop_front();
        if (seen_word.frame_type !== due_word.frame_type)
          flag_mismatch("frame_type", 16'(seen_word.frame_type), 16'(due_word.frame_type));
        if (seen_word.sequence_res !== due_word.sequence_res)
          flag_mismatch("sequence_res", seen_word.sequence_res, due_word.sequence_res);
        if (seen_word.length !== due_word.length)
          flag_mismatch("length", 16'(seen_word.length), 16'(due_word.length));
        if (seen_word.has_data !== due_word.has_data)
          flag_mismatch("has_data", 16'(seen_word.has_data), 16'(due_word.has_data));
        if (seen_word.byte_index !== due_word.byte_index)
          flag_mismatch("byte_index", 16'(seen_word.byte_index), 16'(due_word.byte_index));
        if (seen_word.data_byte !== due_word.data_byte)
          flag_mismatch("data_byte", 16'(seen_word.data_byte), 16'(due_word.data_byte));
        if (seen_word.last !== due_word.last)
          flag_mismatch("last", 16'(seen_word.last), 16'(due_word.last));
      end
      word_count++;
    end
  end

  // Main sequence: reset, directed table, random phases, verdict.
  initial begin
    cfg_sf = START_FIRST_RST;
    cfg_ss = START_SECOND_RST;
    cfg_ml = MAX_LEN_RST;
    p_type = '0;
    p_seq  = '0;
    p_crc  = CRC_INIT;
    restart_hunt();

    // Directed frames under the reset register values.
    plan[0] = mk_row(LEAD_NONE,   8'h00, 16'h0000, 16'd0,      1'b1, CHK_EMPTY);
    plan[1] = mk_row(LEAD_NONE,   8'hFF, 16'hFFFF, 16'd1,      1'b1, CHK_MODEL);
    plan[2] = mk_row(LEAD_NONE,   8'h3C, 16'h0102, 16'd2,      1'b0, CHK_NONE);
    plan[3] = mk_row(LEAD_NONE,   8'h11, 16'h2222, 16'd65,     1'b1, CHK_NONE);
    plan[4] = mk_row(LEAD_NONE,   8'h44, 16'h8001, 16'hFFFF,   1'b1, CHK_NONE);
    plan[5] = mk_row(LEAD_REPEAT, 8'h81, 16'h00FF, 16'd1,      1'b1, CHK_MODEL);
    plan[6] = mk_row(LEAD_BROKEN, 8'h7F, 16'hFF00, 16'd1,      1'b1, CHK_MODEL);
    plan[7] = mk_row(LEAD_NONE,   8'h5A, 16'h1234, 16'd0,      1'b0, CHK_NONE);
    plan[8] = mk_row(LEAD_NONE,   8'hFF, 16'hFFFF, 16'd0,      1'b1, CHK_EMPTY);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      chk_mode = plan[i].chk;
      lit_word = '0;
      lit_word.frame_type   = plan[i].ftype;
      lit_word.sequence_res = plan[i].seq;
      lit_word.last         = 1'b1;
      send_frame(plan[i].lead, plan[i].ftype, plan[i].seq, plan[i].len, plan[i].crc_ok);
    end
    chk_mode = CHK_MODEL;
    wait_idle();

    // Extreme start values with no payload allowed; spare index written too.
    program_regs(8'h00, 8'hFF, 8'd0, 1'b1);
    random_phase(20);
    wait_idle();

    // Top start values; max_len write with every data bit set.
    program_regs(8'hFF, 8'h00, 8'hFF, 1'b0);
    random_phase(40);
    wait_idle();

    // Equal start values and a small length limit.
    program_regs(8'h7E, 8'h7E, 8'd8, 1'b1);
    random_phase(20);
    wait_idle();

    // Random start values and limit.
    program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(64, 1)), 1'b0);
    random_phase(30);
    wait_idle();

    // Default values again, run with no gaps and no back-pressure.
    idle_pct = 0;
    program_regs(START_FIRST_RST, START_SECOND_RST, 8'(MAX_LEN_RST), 1'b0);
    random_phase(60);
    idle_pct = IDLE_PCT;
    random_phase(20);
    wait_idle();

    if (err_count == 0) begin
      $display("crc16_frame_receiver_top regression: pass");
    end else begin
      $display("crc16_frame_receiver_top regression: fail");
    end
    $finish;
  end

endmodule
